### design/khr_pkg.sv
package khr_pkg;

  // Default sizes
  localparam int unsigned USAGE_SLOTS_DEF = 4;
  localparam int unsigned MAP_ENTRIES_DEF = 246;
  localparam int unsigned REPORT_SLOTS    = 4;

  // Event codes
  localparam logic [4:0] EV_KEY      = 5'd1;
  localparam logic [1:0] VAL_RELEASE = 2'd0;
  localparam logic [1:0] VAL_PRESS   = 2'd1;

  // Modifier key codes
  localparam logic [9:0] KC_LCTRL  = 10'd29;
  localparam logic [9:0] KC_LSHIFT = 10'd42;
  localparam logic [9:0] KC_LALT   = 10'd56;
  localparam logic [9:0] KC_LGUI   = 10'd125;
  localparam logic [9:0] KC_RCTRL  = 10'd97;
  localparam logic [9:0] KC_RSHIFT = 10'd54;
  localparam logic [9:0] KC_RALT   = 10'd100;
  localparam logic [9:0] KC_RGUI   = 10'd126;

  // Command broadcast to every slot cell
  typedef struct packed {
    logic       press;
    logic       release_key;
    logic [7:0] usage;
  } khr_cmd_t;

  // Chain signals handed from one cell to the next
  typedef struct packed {
    logic hit;    // usage matched in an earlier cell
    logic empty;  // an earlier cell is empty
  } khr_chain_t;

  // One report word
  typedef struct packed {
    logic       tail_bytes;
    logic [7:0] usage_slot_d;
    logic [7:0] usage_slot_c;
    logic [7:0] usage_slot_b;
    logic [7:0] usage_slot_a;
    logic       reserved_byte;
    logic [7:0] modifier_bits;
  } khr_report_t;

  function automatic logic [7:0] modifier_mask(input logic [9:0] code);
    logic [7:0] m;
    m = 8'h00;
    case (code)
      KC_LCTRL:  m = 8'h10;
      KC_LSHIFT: m = 8'h20;
      KC_LALT:   m = 8'h40;
      KC_LGUI:   m = 8'h80;
      KC_RCTRL:  m = 8'h01;
      KC_RSHIFT: m = 8'h02;
      KC_RALT:   m = 8'h04;
      KC_RGUI:   m = 8'h08;
      default:   m = 8'h00;
    endcase
    return m;
  endfunction

  // Key code to HID usage; codes past the last listed one map to zero
  function automatic logic [7:0] usage_rom(input logic [7:0] code);
    logic [7:0] u;
    u = 8'h00;
    case (code)
      8'd1:  u = 8'h29;  8'd2:  u = 8'h1e;  8'd3:  u = 8'h1f;  8'd4:  u = 8'h20;
      8'd5:  u = 8'h21;  8'd6:  u = 8'h22;  8'd7:  u = 8'h23;  8'd8:  u = 8'h24;
      8'd9:  u = 8'h25;  8'd10: u = 8'h26;  8'd11: u = 8'h27;  8'd12: u = 8'h2d;
      8'd13: u = 8'h2e;  8'd14: u = 8'h2a;  8'd15: u = 8'h2b;  8'd16: u = 8'h14;
      8'd17: u = 8'h1a;  8'd18: u = 8'h08;  8'd19: u = 8'h15;  8'd20: u = 8'h17;
      8'd21: u = 8'h1c;  8'd22: u = 8'h18;  8'd23: u = 8'h0c;  8'd24: u = 8'h12;
      8'd25: u = 8'h13;  8'd26: u = 8'h2f;  8'd27: u = 8'h30;  8'd28: u = 8'h28;
      8'd30: u = 8'h04;  8'd31: u = 8'h16;  8'd32: u = 8'h07;  8'd33: u = 8'h09;
      8'd34: u = 8'h0a;  8'd35: u = 8'h0b;  8'd36: u = 8'h0d;  8'd37: u = 8'h0e;
      8'd38: u = 8'h0f;  8'd39: u = 8'h33;  8'd40: u = 8'h34;  8'd43: u = 8'h31;
      8'd44: u = 8'h1d;  8'd45: u = 8'h1b;  8'd46: u = 8'h06;  8'd47: u = 8'h19;
      8'd48: u = 8'h05;  8'd49: u = 8'h11;  8'd50: u = 8'h10;  8'd51: u = 8'h36;
      8'd52: u = 8'h37;  8'd53: u = 8'h38;  8'd57: u = 8'h2c;  8'd58: u = 8'h39;
      8'd59: u = 8'h3a;  8'd60: u = 8'h3b;  8'd61: u = 8'h3c;  8'd62: u = 8'h3d;
      8'd63: u = 8'h3e;  8'd64: u = 8'h3f;  8'd65: u = 8'h40;  8'd66: u = 8'h41;
      8'd67: u = 8'h42;  8'd68: u = 8'h43;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

### design/khr_cell.sv
module khr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  khr_pkg::khr_cmd_t   cmd_i,
  input  khr_pkg::khr_chain_t chain_i,
  output khr_pkg::khr_chain_t chain_o,
  input  logic [7:0]          right_i,   // held usage of the next cell
  output logic [7:0]          slot_q_o,
  output logic [7:0]          slot_d_o
);
  import khr_pkg::*;

  logic [7:0] slot_q, slot_d;
  logic       is_empty, is_match;

  assign is_empty = (slot_q == 8'h00);
  assign is_match = !is_empty && (slot_q == cmd_i.usage);

  // Pass match and empty flags down the row
  assign chain_o.hit   = chain_i.hit || is_match;
  assign chain_o.empty = chain_i.empty || is_empty;

  // Press fills the first empty cell unless held earlier; release shifts left from the match
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.press && is_empty && !chain_i.empty && !chain_i.hit) begin
      slot_d = cmd_i.usage;
    end else if (cmd_i.release_key && (chain_i.hit || is_match)) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 8'h00;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_q_o = slot_q;
  assign slot_d_o = slot_d;

endmodule

### design/key_event_to_hid_report.sv
// Key event to USB boot-keyboard report builder. Each input word carries one
// input event: its type on tuser, its code and value on tdata. A key press or
// release of a code below MAP_ENTRIES updates the modifier byte or the held-key
// list and emits one 48-bit report word; other events emit nothing. Held keys
// live in a row of USAGE_SLOTS cells that pass match/empty flags along the row,
// so a press lands in the first free slot and a release shifts the later slots
// left in the same cycle. One event is taken every clock while the output buffer
// has room; each report is registered into that buffer as its event is taken.
// The buffer holds two words, so input continues while one report waits;
// input stalls only when both words are full.
module key_event_to_hid_report #(
  parameter int unsigned USAGE_SLOTS = khr_pkg::USAGE_SLOTS_DEF,
  parameter int unsigned MAP_ENTRIES = khr_pkg::MAP_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] event_code, [11:10] event_value, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  // [4:0] event_type
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] modifier_bits, [8] reserved_byte, [16:9] usage_slot_a,
  // [24:17] usage_slot_b, [32:25] usage_slot_c, [40:33] usage_slot_d,
  // [41] tail_bytes, [47:42] zero
  output logic [47:0] m_axis_tdata
);
  import khr_pkg::*;

  logic [4:0] event_type;
  logic [9:0] event_code;
  logic [1:0] event_value;
  logic       accept, key_evt, is_press, is_mod;
  logic [7:0] mask, usage;
  logic [7:0] mod_q, mod_d;
  khr_cmd_t   cmd;

  assign event_type  = s_axis_tuser;
  assign event_code  = s_axis_tdata[9:0];
  assign event_value = s_axis_tdata[11:10];

  // Decode
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_press = (event_value == VAL_PRESS);
  assign key_evt  = accept && (event_type == EV_KEY) && (event_code < 10'(MAP_ENTRIES))
                    && (is_press || (event_value == VAL_RELEASE));
  assign mask     = modifier_mask(event_code);
  assign usage    = usage_rom(event_code[7:0]);
  assign is_mod   = (mask != 8'h00);

  assign cmd.usage       = usage;
  assign cmd.press       = key_evt && !is_mod && is_press && (usage != 8'h00);
  assign cmd.release_key = key_evt && !is_mod && !is_press && (usage != 8'h00);

  // Modifier byte
  always_comb begin
    mod_d = mod_q;
    if (key_evt && is_mod) begin
      mod_d = is_press ? (mod_q | mask) : (mod_q & ~mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= 8'h00;
    end else begin
      mod_q <= mod_d;
    end
  end

  // Row of slot cells
  khr_chain_t chain [USAGE_SLOTS+1];
  logic [7:0] slot_q [USAGE_SLOTS];
  logic [7:0] slot_d [USAGE_SLOTS];

  assign chain[0].hit   = 1'b0;
  assign chain[0].empty = 1'b0;

  for (genvar i = 0; i < USAGE_SLOTS; i++) begin : g_cell
    logic [7:0] right;
    if (i == USAGE_SLOTS - 1) begin : g_last
      assign right = 8'h00;
    end else begin : g_mid
      assign right = slot_q[i+1];
    end
    khr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1]),
      .right_i  (right),
      .slot_q_o (slot_q[i]),
      .slot_d_o (slot_d[i])
    );
  end

  // Assemble the report from the updated state
  logic [7:0]  rpt_slot [REPORT_SLOTS];
  khr_report_t rpt;

  for (genvar k = 0; k < REPORT_SLOTS; k++) begin : g_rpt
    if (k < USAGE_SLOTS) begin : g_have
      assign rpt_slot[k] = slot_d[k];
    end else begin : g_none
      assign rpt_slot[k] = 8'h00;
    end
  end

  assign rpt.modifier_bits = mod_d;
  assign rpt.reserved_byte = 1'b0;
  assign rpt.usage_slot_a  = rpt_slot[0];
  assign rpt.usage_slot_b  = rpt_slot[1];
  assign rpt.usage_slot_c  = rpt_slot[2];
  assign rpt.usage_slot_d  = rpt_slot[3];
  assign rpt.tail_bytes    = 1'b0;

  // Two-word output buffer, head in entry 0
  khr_report_t buf_q [2];
  khr_report_t buf_d [2];
  logic [1:0]  cnt_q, cnt_d, wr_pos;
  logic        push, pop;

  assign push = key_evt;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    buf_d[0] = buf_q[0];
    buf_d[1] = buf_q[1];
    if (pop) begin
      buf_d[0] = buf_q[1];
    end
    wr_pos = cnt_q - {1'b0, pop};
    if (push) begin
      buf_d[wr_pos[0]] = rpt;
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {6'b0, buf_q[0]};

endmodule

### design/khr_checker.sv
module khr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [4:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import khr_pkg::*;

  logic [7:0] sa, sb, sc, sd;
  logic       ignored;

  assign sa = m_axis_tdata[16:9];
  assign sb = m_axis_tdata[24:17];
  assign sc = m_axis_tdata[32:25];
  assign sd = m_axis_tdata[40:33];

  // Non-key events and repeat or unknown values make no report
  assign ignored = (s_axis_tuser != EV_KEY) || s_axis_tdata[11];

  // Stalled report word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("report word changed while stalled");

  // Fixed-zero report bytes
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8] == 1'b0) && (m_axis_tdata[47:41] == 7'd0))
    else $error("reserved report bits not zero");

  // Held keys stay packed toward the first slot
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sb == 8'h00 || sa != 8'h00) && (sc == 8'h00 || sb != 8'h00)
                      && (sd == 8'h00 || sc != 8'h00))
    else $error("held key list has a gap");

  // No usage is held twice
  a_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sb == 8'h00 || (sb != sa))
                      && (sc == 8'h00 || (sc != sa && sc != sb))
                      && (sd == 8'h00 || (sd != sa && sd != sb && sd != sc)))
    else $error("usage held in two slots");

  // An ignored event into an empty buffer leaves it empty
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid && ignored |=> !m_axis_tvalid)
    else $error("report emitted for an ignored event");

endmodule

bind key_event_to_hid_report khr_checker u_khr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/key_event_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the key event to HID report block, keeps its own
// copy of the modifier byte and the held-key slots, and compares every
// report word with the oldest predicted one.
module key_event_checker
  import khr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] in_data_i,
  input  logic [4:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [47:0] out_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          reports_o
);

  localparam int unsigned SLOTS     = USAGE_SLOTS_DEF;
  localparam int unsigned LAST_USED = 68;  // key codes above this map to zero

  // Predicted state
  logic [7:0]  mods_q;
  logic [7:0]  slots_q [SLOTS];
  logic [7:0]  usage_map [0:LAST_USED];
  khr_report_t expected_reports [$];

  initial begin
    usage_map = '{
      8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
      8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
      8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'h00, 8'h04, 8'h16,
      8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
      8'h34, 8'h00, 8'h00, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
      8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00,
      8'h00, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
      8'h3f, 8'h40, 8'h41, 8'h42, 8'h43
    };
  end

  // Left modifiers sit in the upper nibble
  function automatic logic [7:0] mod_bit(input logic [9:0] code);
    logic [7:0] m;
    m = 8'h00;
    if (code == KC_LCTRL)  m = 8'h10;
    if (code == KC_LSHIFT) m = 8'h20;
    if (code == KC_LALT)   m = 8'h40;
    if (code == KC_LGUI)   m = 8'h80;
    if (code == KC_RCTRL)  m = 8'h01;
    if (code == KC_RSHIFT) m = 8'h02;
    if (code == KC_RALT)   m = 8'h04;
    if (code == KC_RGUI)   m = 8'h08;
    return m;
  endfunction

  // Apply one event to the predicted state; emits is low for ignored events
  task automatic apply_event(input logic [4:0] user, input logic [15:0] word,
                             output logic emits, output khr_report_t rpt);
    logic [4:0] ev_type;
    logic [9:0] ev_code;
    logic [1:0] ev_val;
    logic [7:0] mask;
    logic [7:0] usage;
    int         pos;
    logic       placed;
    ev_type = user;
    ev_code = word[9:0];
    ev_val  = word[11:10];
    emits   = 1'b0;
    rpt     = '0;
    if (ev_type != EV_KEY || ev_code >= 10'(MAP_ENTRIES_DEF)) return;
    if (ev_val != VAL_PRESS && ev_val != VAL_RELEASE) return;
    emits = 1'b1;
    mask  = mod_bit(ev_code);
    usage = (ev_code <= 10'(LAST_USED)) ? usage_map[ev_code[6:0]] : 8'h00;
    if (mask != 8'h00) begin
      if (ev_val == VAL_PRESS) mods_q = mods_q | mask;
      else mods_q = mods_q & ~mask;
    end else if (usage != 8'h00) begin
      pos = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (pos < 0 && slots_q[i] == usage) pos = i;
      end
      if (ev_val == VAL_PRESS) begin
        // first free slot, dropped when full or already held
        placed = (pos >= 0);
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && slots_q[i] == 8'h00) begin
            slots_q[i] = usage;
            placed     = 1'b1;
          end
        end
      end else if (pos >= 0) begin
        // release closes the gap toward slot 0
        for (int i = pos; i < SLOTS - 1; i++) slots_q[i] = slots_q[i + 1];
        slots_q[SLOTS - 1] = 8'h00;
      end
    end
    rpt.modifier_bits = mods_q;
    rpt.usage_slot_a  = (SLOTS > 0) ? slots_q[0] : 8'h00;
    rpt.usage_slot_b  = (SLOTS > 1) ? slots_q[1] : 8'h00;
    rpt.usage_slot_c  = (SLOTS > 2) ? slots_q[2] : 8'h00;
    rpt.usage_slot_d  = (SLOTS > 3) ? slots_q[3] : 8'h00;
  endtask

  task automatic note_failure(input string msg);
    errors_o++;
    if (errors_o <= 10) $display("[%0t] checker: %s", $realtime, msg);
  endtask

  // Compare one report word with the oldest prediction
  task automatic check_report(input logic [47:0] word);
    khr_report_t got;
    khr_report_t want;
    got = word[41:0];
    reports_o++;
    if (expected_reports.size() == 0) begin
      note_failure($sformatf("report with nothing expected: %012h", word));
      return;
    end
    want = expected_reports.pop_front();
    if (got.modifier_bits !== want.modifier_bits || got.reserved_byte !== want.reserved_byte ||
        got.usage_slot_a !== want.usage_slot_a || got.usage_slot_b !== want.usage_slot_b ||
        got.usage_slot_c !== want.usage_slot_c || got.usage_slot_d !== want.usage_slot_d ||
        got.tail_bytes !== want.tail_bytes)
      note_failure($sformatf(
        {"report %0d: expected mod=%02h rsv=%b keys=%02h %02h %02h %02h tail=%b, ",
         "got mod=%02h rsv=%b keys=%02h %02h %02h %02h tail=%b"},
        reports_o, want.modifier_bits, want.reserved_byte, want.usage_slot_a,
        want.usage_slot_b, want.usage_slot_c, want.usage_slot_d, want.tail_bytes,
        got.modifier_bits, got.reserved_byte, got.usage_slot_a, got.usage_slot_b,
        got.usage_slot_c, got.usage_slot_d, got.tail_bytes));
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
    reports_o = 0;
  end

  // Words move on the rising edge; outputs first, then the new event
  always @(posedge clk_i or negedge rst_ni) begin
    logic        emits;
    khr_report_t rpt;
    if (!rst_ni) begin
      mods_q = 8'h00;
      for (int i = 0; i < SLOTS; i++) slots_q[i] = 8'h00;
      expected_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_report(out_data_i);
      if (in_valid_i && in_ready_i) begin
        apply_event(in_user_i, in_data_i, emits, rpt);
        if (emits) expected_reports.push_back(rpt);
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

### test/key_event_to_hid_report_tb.sv
`timescale 1ns / 1ps

module key_event_to_hid_report_tb;
  import khr_pkg::*;

  localparam int CHUNKS       = 9;
  localparam int CHUNK_EVENTS = 150;   // event words offered per chunk
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 20;

  // Key codes used by the directed part
  localparam logic [9:0] CODE_NONE     = 10'd0;    // maps to no usage
  localparam logic [9:0] CODE_ESC      = 10'd1;
  localparam logic [9:0] CODE_1        = 10'd2;
  localparam logic [9:0] CODE_2        = 10'd3;
  localparam logic [9:0] CODE_3        = 10'd4;
  localparam logic [9:0] CODE_B        = 10'd48;
  localparam logic [9:0] CODE_F10      = 10'd68;   // last entry with a usage
  localparam logic [9:0] CODE_LAST     = 10'd245;  // last code inside the map
  localparam logic [9:0] CODE_OUTSIDE  = 10'd246;
  localparam logic [9:0] CODE_TOP      = 10'd767;
  localparam logic [1:0] VAL_REPEAT    = 2'd2;
  localparam logic [1:0] VAL_UNKNOWN   = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [4:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  int errors;
  int pending;
  int reports;
  int offered;
  int gap_pct;
  int stall_pct;
  bit hold_req;

  logic [9:0] modifier_codes [8];

  key_event_to_hid_report u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  key_event_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .reports_o   (reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Report side: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    int held;
    bit hold_done;
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one event word, after an optional idle burst; returns at a falling edge
  task automatic send_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
                            input logic [1:0] ev_val);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {4'd0, 12'($urandom)};
      s_axis_tuser  <= 5'($urandom);
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, ev_val, ev_code};
    s_axis_tuser  <= ev_type;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    offered++;
  endtask

  // Stop offering and wait until every predicted report has come out
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly a dozen common keys so the slots fill, collide and shift
  function automatic logic [9:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return modifier_codes[$urandom_range(0, 7)];
    if (r < 70) return 10'($urandom_range(1, 12));
    if (r < 90) return 10'($urandom_range(0, 68));
    return 10'($urandom_range(0, MAP_ENTRIES_DEF - 1));
  endfunction

  // Random events until the given number of event words went in
  task automatic run_chunk(input int n_events);
    int         n;
    int         kind;
    logic [4:0] t;
    logic [9:0] c;
    logic [1:0] v;
    n = 0;
    while (n < n_events) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        v = ($urandom_range(0, 99) < 55) ? VAL_PRESS : VAL_RELEASE;
        send_event(EV_KEY, pick_code(), v);
      end else if (kind < 86) begin
        send_event(EV_KEY, pick_code(), 2'($urandom_range(VAL_REPEAT, VAL_UNKNOWN)));
      end else begin
        t = 5'($urandom_range(0, 31));
        c = 10'($urandom_range(0, 767));
        v = 2'($urandom_range(0, 3));
        send_event(t, c, v);
      end
      n++;
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_req      = 1'b0;
    offered       = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    modifier_codes = '{KC_LCTRL, KC_LSHIFT, KC_LALT, KC_LGUI,
                       KC_RCTRL, KC_RSHIFT, KC_RALT, KC_RGUI};
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ignored events first, none of these reports
    send_event(5'd0, CODE_ESC, VAL_PRESS);
    send_event(5'd31, CODE_ESC, VAL_PRESS);
    send_event(EV_KEY, CODE_OUTSIDE, VAL_PRESS);
    send_event(EV_KEY, CODE_TOP, VAL_RELEASE);
    send_event(EV_KEY, CODE_ESC, VAL_REPEAT);
    send_event(EV_KEY, CODE_ESC, VAL_UNKNOWN);
    // unmapped keys still report
    send_event(EV_KEY, CODE_NONE, VAL_PRESS);
    send_event(EV_KEY, CODE_LAST, VAL_PRESS);
    // fill the slots, press a held key again, overflow
    send_event(EV_KEY, CODE_ESC, VAL_PRESS);
    send_event(EV_KEY, CODE_F10, VAL_PRESS);
    send_event(EV_KEY, CODE_ESC, VAL_PRESS);
    send_event(EV_KEY, CODE_1, VAL_PRESS);
    send_event(EV_KEY, CODE_2, VAL_PRESS);
    send_event(EV_KEY, CODE_3, VAL_PRESS);
    // release from the middle shifts left; release of a key not held
    send_event(EV_KEY, CODE_F10, VAL_RELEASE);
    send_event(EV_KEY, CODE_B, VAL_RELEASE);
    // every modifier on, two off again
    for (int i = 0; i < 8; i++) send_event(EV_KEY, modifier_codes[i], VAL_PRESS);
    send_event(EV_KEY, KC_LCTRL, VAL_RELEASE);
    send_event(EV_KEY, KC_RGUI, VAL_RELEASE);

    // Random chunks with varying idling; last chunk runs flat out
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == CHUNKS - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (chunk == 2) hold_req = 1'b1;
      run_chunk(CHUNK_EVENTS);
      if (chunk == 4 || chunk == 6) drain_reports();
    end

    drain_reports();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run: %0d events offered, %0d reports compared, %0d mismatches.",
             offered, reports, errors);
    $display("Covered ignored events, full and shifting slots, modifiers, a long hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
